[hw/rtl/assert_macros.svh]
// Assertion macros shared by the particle update RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define PRLPU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define PRLPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/prlpu_pkg.sv]
// Shared types and constants of the particle velocity and position update
package prlpu_pkg;

   localparam int DATA_W        = 32;
   localparam int LIMIT_W       = 31;
   localparam int RAND_W        = 16;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int RAND_BITS_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INERTIA   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COGNITIVE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SOCIAL    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VLIMIT    = 2'd3;

   // register reset values
   localparam logic [DATA_W-1:0]  INERTIA_RST   = 32'd58982;
   localparam logic [DATA_W-1:0]  COGNITIVE_RST = 32'd65536;
   localparam logic [DATA_W-1:0]  SOCIAL_RST    = 32'd65536;
   localparam logic [LIMIT_W-1:0] VLIMIT_RST    = 31'd6554;

   typedef struct packed {
      logic [DATA_W-1:0]  inertia_weight;
      logic [DATA_W-1:0]  cognitive_gain;
      logic [DATA_W-1:0]  social_gain;
      logic [LIMIT_W-1:0] velocity_limit;
   } cfg_type;

   // fields the position stages need, carried along the velocity stages (which also read position)
   typedef struct packed {
      logic [DATA_W-1:0]  position;
      logic               is_first;
      logic [DATA_W-1:0]  prev_position;
      logic [DATA_W-1:0]  window_low;
      logic [DATA_W-1:0]  window_high;
      logic [LIMIT_W-1:0] rate_limit;
   } side_type;

   typedef struct packed {
      logic [DATA_W-1:0] velocity;
      logic [DATA_W-1:0] personal_best;
      logic [DATA_W-1:0] global_best;
      logic [RAND_W-1:0] rand_cognitive;
      logic [RAND_W-1:0] rand_social;
      side_type          side;
   } vel_in_type;

   typedef struct packed {
      logic [DATA_W-1:0] new_velocity;
      side_type          side;
   } vel_out_type;

   typedef struct packed {
      logic [DATA_W-1:0] new_position;
      logic [DATA_W-1:0] new_velocity;
   } rsp_type;

endpackage

[hw/rtl/prlpu_req_if.sv]
// Request channel: one particle element word with valid and ready
interface prlpu_req_if import prlpu_pkg::*;;
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  position;
   logic [DATA_W-1:0]  velocity;
   logic [DATA_W-1:0]  personal_best;
   logic [DATA_W-1:0]  global_best;
   logic [RAND_W-1:0]  rand_cognitive;
   logic [RAND_W-1:0]  rand_social;
   logic               is_first;
   logic [DATA_W-1:0]  prev_position;
   logic [DATA_W-1:0]  window_low;
   logic [DATA_W-1:0]  window_high;
   logic [LIMIT_W-1:0] rate_limit;

   modport source (
      output valid, position, velocity, personal_best, global_best,
             rand_cognitive, rand_social, is_first, prev_position,
             window_low, window_high, rate_limit,
      input  ready
   );

   modport sink (
      input  valid, position, velocity, personal_best, global_best,
             rand_cognitive, rand_social, is_first, prev_position,
             window_low, window_high, rate_limit,
      output ready
   );
endinterface

[hw/rtl/prlpu_rsp_if.sv]
// Response channel: updated position and velocity word with valid and ready
interface prlpu_rsp_if import prlpu_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] new_position;
   logic [DATA_W-1:0] new_velocity;

   modport source (
      output valid, new_position, new_velocity,
      input  ready
   );

   modport sink (
      input  valid, new_position, new_velocity,
      output ready
   );
endinterface

[hw/rtl/prlpu_velocity.sv]
// Velocity stages: gain products, difference products, sum and saturation
`include "assert_macros.svh"

module prlpu_velocity import prlpu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int RAND_BITS = RAND_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  vel_in_type  in_word,
   output logic        out_valid,
   input  logic        out_ready,
   output vel_out_type out_word
);

   localparam int RAND_KEEP = (RAND_BITS < RAND_W) ? RAND_BITS : RAND_W;
   localparam logic [RAND_W-1:0] RAND_MASK = RAND_W'((32'd1 << RAND_KEEP) - 32'd1);
   localparam int GPROD_W = DATA_W + RAND_W + 1;
   localparam int WPROD_W = 2 * DATA_W;
   localparam int DIFF_W  = DATA_W + 1;
   localparam int TPROD_W = DATA_W + DIFF_W;
   localparam int WV_W    = WPROD_W - FRAC_BITS;
   localparam int T_W     = TPROD_W - FRAC_BITS;
   localparam int SUM_W   = TPROD_W + 2 - FRAC_BITS;

   // stage enables: a stage loads when it is empty or its word moves on
   logic en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 1: effective gains, inertia term, position differences
   logic        [RAND_W-1:0]  r1_mask, r2_mask;
   logic signed [GPROD_W-1:0] gp1, gp2, gs1, gs2;
   logic signed [WPROD_W-1:0] wp, ws;
   logic signed [DATA_W-1:0]  g1_in, g2_in, g1_ff, g2_ff;
   logic signed [WV_W-1:0]    wv1_in, wv1_ff, wv2_ff;
   logic signed [DIFF_W-1:0]  d1_in, d2_in, d1_ff, d2_ff;
   side_type                  side1_ff, side2_ff, side3_ff;

   always_comb begin
      r1_mask = in_word.rand_cognitive & RAND_MASK;
      r2_mask = in_word.rand_social & RAND_MASK;
      gp1     = $signed(cfg.cognitive_gain) * $signed({1'b0, r1_mask});
      gp2     = $signed(cfg.social_gain) * $signed({1'b0, r2_mask});
      gs1     = gp1 >>> RAND_BITS;
      gs2     = gp2 >>> RAND_BITS;
      g1_in   = gs1[DATA_W-1:0];
      g2_in   = gs2[DATA_W-1:0];
      wp      = $signed(cfg.inertia_weight) * $signed(in_word.velocity);
      ws      = wp >>> FRAC_BITS;
      wv1_in  = ws[WV_W-1:0];
      d1_in   = DIFF_W'($signed(in_word.personal_best)) - DIFF_W'($signed(in_word.side.position));
      d2_in   = DIFF_W'($signed(in_word.global_best)) - DIFF_W'($signed(in_word.side.position));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         g1_ff    <= g1_in;
         g2_ff    <= g2_in;
         wv1_ff   <= wv1_in;
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         side1_ff <= in_word.side;
      end
   end

   // stage 2: attraction terms
   logic signed [TPROD_W-1:0] tp1, tp2, ts1, ts2;
   logic signed [T_W-1:0]     t1_in, t2_in, t1_ff, t2_ff;

   always_comb begin
      tp1   = g1_ff * d1_ff;
      tp2   = g2_ff * d2_ff;
      ts1   = tp1 >>> FRAC_BITS;
      ts2   = tp2 >>> FRAC_BITS;
      t1_in = ts1[T_W-1:0];
      t2_in = ts2[T_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
         wv2_ff   <= wv1_ff;
         side2_ff <= side1_ff;
      end
   end

   // stage 3: full-width sum, saturate to the velocity limit
   logic signed [SUM_W-1:0]  sum, vlim_ext;
   logic signed [DATA_W-1:0] nv_in, nv_ff;

   always_comb begin
      sum      = SUM_W'(wv2_ff) + SUM_W'(t1_ff) + SUM_W'(t2_ff);
      vlim_ext = SUM_W'($signed({1'b0, cfg.velocity_limit}));
      priority if (sum > vlim_ext) begin
         nv_in = vlim_ext[DATA_W-1:0];
      end else if (sum < -vlim_ext) begin
         nv_in = DATA_W'(-vlim_ext);
      end else begin
         nv_in = sum[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         nv_ff    <= nv_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid             = v3_ff;
   assign out_word.new_velocity = nv_ff;
   assign out_word.side         = side3_ff;

   // a refused word means every stage holds one
   `PRLPU_ASSERT_NOW(a_full_when_refused, clock, reset, !in_ready, v1_ff && v2_ff && v3_ff, "stall with empty stage")
   // an accepted word lands in stage 1
   `PRLPU_ASSERT_NEXT(a_accept_lands, clock, reset, in_valid && in_ready, v1_ff, "accepted word lost")

endmodule

[hw/rtl/prlpu_position.sv]
// Position stages: move, rate limit against the previous element, box clamp
`include "assert_macros.svh"

module prlpu_position import prlpu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  vel_out_type in_word,
   output logic        out_valid,
   input  logic        out_ready,
   output rsp_type     out_word
);

   localparam int POS_W = DATA_W + 2;

   logic en4, en5;
   logic v4_ff, v5_ff;

   assign en5      = !v5_ff || out_ready;
   assign en4      = !v4_ff || en5;
   assign in_ready = en4;

   // stage 4: move and rate limit
   logic signed [POS_W-1:0] nx, dlt, prev_ext, du_ext, rl_in, rl_ff;
   logic signed [POS_W-1:0] lim_hi, lim_lo;
   logic [DATA_W-1:0]       nv4_ff, lo4_ff, hi4_ff, prev4_ff;
   logic [LIMIT_W-1:0]      du4_ff;
   logic                    first4_ff;

   always_comb begin
      prev_ext = POS_W'($signed(in_word.side.prev_position));
      du_ext   = POS_W'($signed({1'b0, in_word.side.rate_limit}));
      nx       = POS_W'($signed(in_word.side.position)) + POS_W'($signed(in_word.new_velocity));
      dlt      = nx - prev_ext;
      rl_in    = nx;
      if (!in_word.side.is_first) begin
         priority if (dlt > du_ext) begin
            rl_in = prev_ext + du_ext;
         end else if (dlt < -du_ext) begin
            rl_in = prev_ext - du_ext;
         end else begin
            rl_in = nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rl_ff      <= rl_in;
         nv4_ff     <= in_word.new_velocity;
         lo4_ff     <= in_word.side.window_low;
         hi4_ff     <= in_word.side.window_high;
         prev4_ff   <= in_word.side.prev_position;
         du4_ff     <= in_word.side.rate_limit;
         first4_ff  <= in_word.side.is_first;
      end
   end

   // stage 5: clamp to the window, upper bound first
   logic signed [POS_W-1:0]  lo_ext, hi_ext;
   logic        [DATA_W-1:0] np_in, np_ff, nv5_ff;

   always_comb begin
      lo_ext = POS_W'($signed(lo4_ff));
      hi_ext = POS_W'($signed(hi4_ff));
      priority if (rl_ff > hi_ext) begin
         np_in = hi4_ff;
      end else if (rl_ff < lo_ext) begin
         np_in = lo4_ff;
      end else begin
         np_in = rl_ff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en5) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         np_ff  <= np_in;
         nv5_ff <= nv4_ff;
      end
   end

   assign out_valid             = v5_ff;
   assign out_word.new_position = np_ff;
   assign out_word.new_velocity = nv5_ff;

   // rate-limited position stays within the step of the previous element
   assign lim_hi = POS_W'($signed(prev4_ff)) + POS_W'($signed({1'b0, du4_ff}));
   assign lim_lo = POS_W'($signed(prev4_ff)) - POS_W'($signed({1'b0, du4_ff}));
   `PRLPU_ASSERT_NOW(a_rate_bound, clock, reset, v4_ff && !first4_ff, (rl_ff <= lim_hi) && (rl_ff >= lim_lo), "rate limit exceeded")

endmodule

[hw/rtl/pso_rate_limited_particle_update_top.sv]
// A request passes the velocity stages, then the position stages, to the response.
// Throughput: one word per cycle; each of the five stages holds one word and
// loads whenever it is empty or its word moves on, so bubbles fill under stall.
// The critical stages are the 32x32 inertia product and the 32x33 attraction products.
// Reset clears all stage valid bits and restores the four registers' defaults.
// Configuration writes take effect at the next clock edge.
module pso_rate_limited_particle_update_top import prlpu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int RAND_BITS = RAND_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   prlpu_req_if.sink             req_chan,
   prlpu_rsp_if.source           rsp_chan
);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_INERTIA:   cfg_in.inertia_weight = csr_data;
            REG_COGNITIVE: cfg_in.cognitive_gain = csr_data;
            REG_SOCIAL:    cfg_in.social_gain    = csr_data;
            REG_VLIMIT:    cfg_in.velocity_limit = csr_data[LIMIT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inertia_weight <= INERTIA_RST;
         cfg_ff.cognitive_gain <= COGNITIVE_RST;
         cfg_ff.social_gain    <= SOCIAL_RST;
         cfg_ff.velocity_limit <= VLIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // gather the request word
   vel_in_type  req_word;
   vel_out_type vel_word;
   rsp_type     rsp_word;
   logic        vel_valid, vel_ready;

   always_comb begin
      req_word.velocity           = req_chan.velocity;
      req_word.personal_best      = req_chan.personal_best;
      req_word.global_best        = req_chan.global_best;
      req_word.rand_cognitive     = req_chan.rand_cognitive;
      req_word.rand_social        = req_chan.rand_social;
      req_word.side.position      = req_chan.position;
      req_word.side.is_first      = req_chan.is_first;
      req_word.side.prev_position = req_chan.prev_position;
      req_word.side.window_low    = req_chan.window_low;
      req_word.side.window_high   = req_chan.window_high;
      req_word.side.rate_limit    = req_chan.rate_limit;
   end

   prlpu_velocity #(
      .FRAC_BITS (FRAC_BITS),
      .RAND_BITS (RAND_BITS)
   ) u_velocity (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_word   (req_word),
      .out_valid (vel_valid),
      .out_ready (vel_ready),
      .out_word  (vel_word)
   );

   prlpu_position u_position (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vel_valid),
      .in_ready  (vel_ready),
      .in_word   (vel_word),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_word  (rsp_word)
   );

   assign rsp_chan.new_position = rsp_word.new_position;
   assign rsp_chan.new_velocity = rsp_word.new_velocity;

endmodule
